// ===== src/mmp2_pkg.sv =====
// shared constants for the 2x2 modular matrix power block
`default_nettype none
package mmp2_pkg;
  // width of the matrix entries and of the exponent on the ports
  localparam int unsigned DATA_W = 32;
  // modulus after reset
  localparam logic [31:0] MODULUS_RESET = 32'd10000007;
  // width of the register byte address; its top bit selects the register index
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic CFG_IDX_MODULUS = 1'b0;
endpackage
`default_nettype wire

// ===== src/modular_matrix_power_2x2.sv =====
// 2x2 matrix power modulo a configured modulus, square-and-multiply with bit-serial mulmod
// operation: the base entries are first reduced, then per exponent bit one matrix square
//   and, for a set bit, one matrix product; each product runs on one shared mulmod unit
//   at one multiplier bit per cycle, and the finished result is then handed off
// throughput: one item at a time; the input stalls until the result is handed off
// reset: synchronous active-low rst_n clears control state and sets modulus to 10000007
`default_nettype none
module modular_matrix_power_2x2 #(
  parameter int unsigned EXP_BITS = 32,
  parameter int unsigned MOD_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [mmp2_pkg::DATA_W-1:0]        in_base_00,
  input  wire logic [mmp2_pkg::DATA_W-1:0]        in_base_01,
  input  wire logic [mmp2_pkg::DATA_W-1:0]        in_base_10,
  input  wire logic [mmp2_pkg::DATA_W-1:0]        in_base_11,
  input  wire logic [mmp2_pkg::DATA_W-1:0]        in_exponent,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [mmp2_pkg::DATA_W-1:0]             out_power_00,
  output logic [mmp2_pkg::DATA_W-1:0]             out_power_01,
  output logic [mmp2_pkg::DATA_W-1:0]             out_power_10,
  output logic [mmp2_pkg::DATA_W-1:0]             out_power_11,
  // configuration port
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [mmp2_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [31:0]                        cfg_pwdata,
  output logic [31:0]                             cfg_prdata,
  output logic                                    cfg_pready
);
  import mmp2_pkg::*;

  localparam int unsigned W     = MOD_BITS;
  localparam int unsigned SW    = MOD_BITS + 2;
  localparam int unsigned DIG_W = $clog2(DATA_W);
  localparam int unsigned CNT_W = $clog2(EXP_BITS + 1);
  localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(DATA_W - 1);

  typedef enum logic [2:0] {S_IDLE, S_LD, S_MUL, S_ADD, S_FIN} state_t;

  state_t               state_r;
  logic [W-1:0]         modulus_r;
  logic [DATA_W-1:0]    base_r [4];
  logic [W-1:0]         acc_r [4];
  logic [W-1:0]         t_r [4];
  logic [EXP_BITS-1:0]  exp_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 red_r;
  logic                 phase_r;
  logic [2:0]           st_r;
  logic [DIG_W-1:0]     dig_r;
  logic [DATA_W-1:0]    mul_a_r;
  logic [W-1:0]         mul_b_r;
  logic [W-1:0]         r_r;
  logic [W-1:0]         p0_r;
  logic [W-1:0]         p1_r;
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_r [4];

  logic [SW-1:0]        mv_w;
  logic                 one_v;
  logic [SW-1:0]        s0, s1, s2, sa;
  logic [W-1:0]         step_v, sum_v;
  logic [DATA_W-1:0]    ld_a;
  logic [W-1:0]         ld_b;
  logic                 cfg_wr;

  // effective modulus: zero stands for 2^MOD_BITS
  assign mv_w  = SW'({modulus_r == '0, modulus_r});
  assign one_v = (modulus_r != W'(1));

  // one digit of interleaved mulmod: r = 2r + a_bit*b, reduced
  always_comb begin
    s0 = SW'({r_r, 1'b0}) + (mul_a_r[DATA_W-1] ? SW'(mul_b_r) : '0);
    s1 = (s0 >= mv_w) ? s0 - mv_w : s0;
    s2 = (s1 >= mv_w) ? s1 - mv_w : s1;
    step_v = W'(s2);
  end

  // modular sum of the two partial products
  always_comb begin
    sa = SW'(p0_r) + SW'(p1_r);
    sum_v = (sa >= mv_w) ? W'(sa - mv_w) : W'(sa);
  end

  // operand select: base reduction, or entry {i,j} half h of a matrix product
  always_comb begin
    if (red_r) begin
      ld_a = base_r[st_r[1:0]];
      ld_b = W'(one_v);
    end else begin
      ld_a = DATA_W'(acc_r[{st_r[2], st_r[0]}]);
      ld_b = phase_r ? W'(base_r[{st_r[0], st_r[1]}]) : acc_r[{st_r[0], st_r[1]}];
    end
  end

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = 32'(modulus_r);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= W'(MODULUS_RESET);
    end else if (cfg_wr && cfg_paddr[2] == CFG_IDX_MODULUS) begin
      modulus_r <= cfg_pwdata[W-1:0];
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      red_r       <= 1'b0;
      phase_r     <= 1'b0;
      st_r        <= '0;
      dig_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_FIN) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            base_r[0] <= in_base_00;
            base_r[1] <= in_base_01;
            base_r[2] <= in_base_10;
            base_r[3] <= in_base_11;
            exp_r     <= EXP_BITS'(in_exponent);
            cnt_r     <= CNT_W'(EXP_BITS);
            acc_r[0]  <= W'(one_v);
            acc_r[1]  <= '0;
            acc_r[2]  <= '0;
            acc_r[3]  <= W'(one_v);
            red_r     <= 1'b1;
            phase_r   <= 1'b0;
            st_r      <= '0;
            state_r   <= S_LD;
          end
        end
        S_LD: begin
          mul_a_r <= ld_a;
          mul_b_r <= ld_b;
          r_r     <= '0;
          dig_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          r_r     <= step_v;
          mul_a_r <= {mul_a_r[DATA_W-2:0], 1'b0};
          dig_r   <= dig_r + 1'b1;
          if (dig_r == DIG_LAST) begin
            if (red_r) begin
              base_r[st_r[1:0]] <= DATA_W'(step_v);
              if (st_r[1:0] == 2'd3) begin
                red_r <= 1'b0;
                st_r  <= '0;
              end else begin
                st_r <= st_r + 1'b1;
              end
              state_r <= S_LD;
            end else if (!st_r[0]) begin
              p0_r    <= step_v;
              st_r    <= st_r + 1'b1;
              state_r <= S_LD;
            end else begin
              p1_r    <= step_v;
              state_r <= S_ADD;
            end
          end
        end
        S_ADD: begin
          t_r[st_r[2:1]] <= sum_v;
          if (st_r != 3'd7) begin
            st_r    <= st_r + 1'b1;
            state_r <= S_LD;
          end else begin
            // matrix product complete
            acc_r[0] <= t_r[0];
            acc_r[1] <= t_r[1];
            acc_r[2] <= t_r[2];
            acc_r[3] <= sum_v;
            st_r     <= '0;
            if (!phase_r && exp_r[EXP_BITS-1]) begin
              phase_r <= 1'b1;
              state_r <= S_LD;
            end else begin
              phase_r <= 1'b0;
              exp_r   <= exp_r << 1;
              cnt_r   <= cnt_r - 1'b1;
              state_r <= (cnt_r == CNT_W'(1)) ? S_FIN : S_LD;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_r[0]    <= DATA_W'(acc_r[0]);
            out_r[1]    <= DATA_W'(acc_r[1]);
            out_r[2]    <= DATA_W'(acc_r[2]);
            out_r[3]    <= DATA_W'(acc_r[3]);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_power_00 = out_r[0];
  assign out_power_01 = out_r[1];
  assign out_power_10 = out_r[2];
  assign out_power_11 = out_r[3];

  // a new result only comes from the handoff state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result valid rose outside handoff");

  // running remainder stays reduced during a multiply
  a_r_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (SW'(r_r) < mv_w))
    else $error("mulmod remainder not reduced");

  // diagonal accumulator entries stay reduced in the add state
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD) |-> (SW'(acc_r[0]) < mv_w) && (SW'(acc_r[3]) < mv_w))
    else $error("accumulator not reduced");

  // exponent bits remain whenever a product is in flight
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LD || state_r == S_MUL || state_r == S_ADD) |-> (cnt_r != '0))
    else $error("exponent counter ran out mid-product");

endmodule
`default_nettype wire

// ===== test/mmp2_checker.sv =====
// checker for the 2x2 modular matrix power block: watches both channels, predicts, compares
`timescale 1ns / 100ps
`default_nettype none
module mmp2_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [31:0] in_base_00,
  input  wire logic [31:0] in_base_01,
  input  wire logic [31:0] in_base_10,
  input  wire logic [31:0] in_base_11,
  input  wire logic [31:0] in_exponent,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] out_power_00,
  input  wire logic [31:0] out_power_01,
  input  wire logic [31:0] out_power_10,
  input  wire logic [31:0] out_power_11,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               fail_count,
  output int               pending_count
);
  import mmp2_pkg::*;

  typedef logic [31:0] mat_t [4];
  typedef struct packed {
    logic [31:0] p00, p01, p10, p11;
  } power_t;

  logic [31:0] modulus_q;
  power_t      power_q[$];

  // reduce a value modulo the modulus, zero meaning 2^32
  function automatic logic [31:0] mod_reduce(logic [63:0] x, logic [31:0] m);
    if (m == 0) return x[31:0];
    return 32'(x % {32'd0, m});
  endfunction

  function automatic mat_t mat_product(mat_t a, mat_t b, logic [31:0] m);
    mat_t r;
    logic [31:0] p0, p1;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) begin
        p0 = mod_reduce({32'd0, a[i*2]} * {32'd0, b[j]}, m);
        p1 = mod_reduce({32'd0, a[i*2+1]} * {32'd0, b[2+j]}, m);
        r[i*2+j] = mod_reduce({32'd0, p0} + {32'd0, p1}, m);
      end
    return r;
  endfunction

  // square-and-multiply from the top exponent bit down
  function automatic power_t matrix_power(logic [31:0] b00, logic [31:0] b01,
                                          logic [31:0] b10, logic [31:0] b11,
                                          logic [31:0] e, logic [31:0] m);
    mat_t base, acc;
    power_t r;
    base[0] = mod_reduce({32'd0, b00}, m);
    base[1] = mod_reduce({32'd0, b01}, m);
    base[2] = mod_reduce({32'd0, b10}, m);
    base[3] = mod_reduce({32'd0, b11}, m);
    acc[0] = mod_reduce(64'd1, m);
    acc[1] = 0;
    acc[2] = 0;
    acc[3] = acc[0];
    for (int k = 31; k >= 0; k--) begin
      acc = mat_product(acc, acc, m);
      if (e[k]) acc = mat_product(acc, base, m);
    end
    r.p00 = acc[0]; r.p01 = acc[1]; r.p10 = acc[2]; r.p11 = acc[3];
    return r;
  endfunction

  assign pending_count = power_q.size();

  always @(posedge clk) begin
    power_t got, want;
    if (!rst_n) begin
      modulus_q <= MODULUS_RESET;
      fail_count <= 0;
      power_q.delete();
    end else begin
      // register write
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
          && cfg_paddr[2] == CFG_IDX_MODULUS)
        modulus_q <= cfg_pwdata;
      // accepted input item
      if (in_valid && !in_stall)
        power_q.push_back(matrix_power(in_base_00, in_base_01, in_base_10, in_base_11,
                                       in_exponent, modulus_q));
      // accepted result item
      if (out_valid && !out_stall) begin
        got = '{out_power_00, out_power_01, out_power_10, out_power_11};
        if (power_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result item %h", got);
        end else begin
          want = power_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected %h %h %h %h, got %h %h %h %h",
                       want.p00, want.p01, want.p10, want.p11,
                       got.p00, got.p01, got.p10, got.p11);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// stimulus and verdict for the 2x2 modular matrix power block
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import mmp2_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic        clk = 0, rst_n = 0;
  logic        in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [31:0] in_base_00 = 0, in_base_01 = 0, in_base_10 = 0, in_base_11 = 0;
  logic [31:0] in_exponent = 0;
  logic [31:0] out_power_00, out_power_01, out_power_10, out_power_11;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0, cfg_pready;
  logic [2:0]  cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0, cfg_prdata;
  int          fail_count, pending_count, idle_cycles;
  bit          calm;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  modular_matrix_power_2x2 DUT (.*);
  mmp2_checker checker_i (.*);

  // receiver stall, none while calm
  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 10);

  // watchdog on cycles with nothing accepted
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_modulus(logic [31:0] m);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= {CFG_IDX_MODULUS, 2'b00}; cfg_pwdata <= m;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  // drop valid, let the checker see the last item, then wait for every result
  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_item(logic [31:0] b00, logic [31:0] b01, logic [31:0] b10,
                           logic [31:0] b11, logic [31:0] e);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_base_00 <= b00; in_base_01 <= b01; in_base_10 <= b10; in_base_11 <= b11;
    in_exponent <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // random exponent, mostly with few set bits to keep the run brief
  function automatic logic [31:0] rand_exp();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 3);
      default: return $urandom_range(0, 255) << $urandom_range(0, 24);
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] moduli[6];
    moduli = '{32'd2, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd97, 32'h8000_0001};
    calm = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    // directed at reset modulus
    send_item(1, 1, 1, 0, 10);
    send_item(5, 6, 7, 8, 0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(0, 0, 0, 0, 32'h8000_0000);
    send_item(0, 0, 0, 0, 0);
    send_item(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    wait_drained();
    // directed per modulus, then random items
    foreach (moduli[k]) begin
      write_modulus(moduli[k]);
      send_item(32'hFFFF_FFFF, 3, 2, 1, 0);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 1);
      send_item($urandom, $urandom, $urandom, $urandom, 32'hFFFF_FFFF);
      calm = (k == 2);
      repeat (14) send_item(rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                            rand_exp());
      calm = 0;
      // sender holds off until the block drains
      wait_drained();
    end
    write_modulus(MODULUS_RESET);
    wait_drained();
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
src/mmp2_pkg.sv
src/modular_matrix_power_2x2.sv
test/mmp2_checker.sv
test/tb.sv
